### rtl/tans_enc_pkg.sv
// Shared types and constants of the tANS symbol encoder.
`default_nettype none

package tans_enc_pkg;

    // Field widths of the input and result words
    localparam int CMD_W    = 2;
    localparam int SYM_W    = 8;
    localparam int COUNT_W  = 12;
    localparam int BASE_W   = 11;
    localparam int SLOT_W   = 11;
    localparam int STATE_W  = 12;
    localparam int BITS_W   = 12;
    localparam int BCNT_W   = 4;

    // Coder table: M slots, state lives in [M, 2M)
    localparam int TABLE_SIZE = 2048;
    localparam int TABLE_AW   = $clog2(TABLE_SIZE);
    localparam logic [STATE_W-1:0] STATE_INIT = STATE_W'(2 * TABLE_SIZE - 1);

    // Command codes carried on s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_SYM  = 2'd0,
        CMD_LOAD_SLOT = 2'd1,
        CMD_ENCODE    = 2'd2,
        CMD_FLUSH     = 2'd3
    } cmd_t;

    // Controller to datapath strobes
    typedef struct packed {
        logic sym_wr;    // write symbol count/base entry
        logic tbl_wr;    // write next-state slot
        logic sym_rd;    // read symbol entry
        logic start;     // encode or flush word accepted
        logic flush;     // accepted word is a flush
        logic shift_ld;  // register renormalization results
        logic tbl_rd;    // read next-state slot
        logic out_ld;    // load output register, update coder state
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sym_zero;  // symbol has no count
        logic out_free;  // output register can take a word this cycle
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/tans_enc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tans_enc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/tans_enc_ctrl.sv
// Command sequencer of the tANS symbol encoder.
`default_nettype none

module tans_enc_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire tans_enc_pkg::cmd_t       command,
    input  wire tans_enc_pkg::dp_status_t status,
    output tans_enc_pkg::ctrl_cmd_t       cmd
);

    import tans_enc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_INDEX = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and datapath strobes
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (command)
                        CMD_LOAD_SYM: begin
                            cmd.sym_wr = 1'b1;
                        end
                        CMD_LOAD_SLOT: begin
                            cmd.tbl_wr = 1'b1;
                        end
                        CMD_ENCODE: begin
                            cmd.sym_rd = 1'b1;
                            cmd.start  = 1'b1;
                            state_next = ST_SHIFT;
                        end
                        CMD_FLUSH: begin
                            cmd.start  = 1'b1;
                            cmd.flush  = 1'b1;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SHIFT: begin
                cmd.shift_ld = 1'b1;
                state_next   = status.sym_zero ? ST_DONE : ST_INDEX;
            end
            ST_INDEX: begin
                cmd.tbl_rd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tans_enc_dpath.sv
// Datapath of the tANS symbol encoder: tables, coder state, output register.
`default_nettype none

module tans_enc_dpath #(
    parameter int ALPHABET = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tans_enc_pkg::ctrl_cmd_t             cmd,
    output tans_enc_pkg::dp_status_t                 status,
    input  wire logic [tans_enc_pkg::SYM_W-1:0]      symbol,
    input  wire logic [tans_enc_pkg::COUNT_W-1:0]    sym_count,
    input  wire logic [tans_enc_pkg::BASE_W-1:0]     sym_base,
    input  wire logic [tans_enc_pkg::SLOT_W-1:0]     slot,
    input  wire logic [tans_enc_pkg::STATE_W-1:0]    slot_state,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [tans_enc_pkg::BITS_W-1:0]     bits,
    output logic      [tans_enc_pkg::BCNT_W-1:0]     bit_count,
    output logic                                     zero_count_error
);

    import tans_enc_pkg::*;

    localparam int SYM_AW = $clog2(ALPHABET);
    localparam int ENT_W  = COUNT_W + BASE_W;
    localparam logic [SYM_W:0] ALPHA_LIM = (SYM_W + 1)'(ALPHABET);

    // Bit length of a state word
    function automatic logic [BCNT_W-1:0] bit_len(input logic [STATE_W-1:0] v);
        logic [BCNT_W-1:0] len;
        len = '0;
        for (int i = 0; i < STATE_W; i++) begin
            if (v[i]) begin
                len = BCNT_W'(i + 1);
            end
        end
        return len;
    endfunction

    logic                  sym_in_range;
    logic [ALPHABET-1:0]   sym_valid_reg;
    logic                  sym_ok_reg;
    logic [ENT_W-1:0]      sym_rd_data;
    logic [COUNT_W-1:0]    rd_count;
    logic [BASE_W-1:0]     rd_base;
    logic [STATE_W-1:0]    tbl_rd_data;
    logic [TABLE_AW-1:0]   tbl_index;

    logic [STATE_W-1:0]    coder_state_reg;
    logic                  flush_reg;
    logic                  err_reg;
    logic [BCNT_W-1:0]     shift_reg, shift_next;
    logic [STATE_W-1:0]    xs_reg, xs_next;
    logic [BITS_W-1:0]     emit_reg, emit_next;
    logic [STATE_W-1:0]    below_lim;
    logic [COUNT_W:0]      two_cnt;

    logic                  m_valid_reg;
    logic [BITS_W-1:0]     bits_reg;
    logic [BCNT_W-1:0]     bit_count_reg;
    logic                  err_out_reg;

    assign sym_in_range = ({1'b0, symbol} < ALPHA_LIM);

    // Symbol count/base store, one entry per symbol
    tans_enc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ALPHABET)
    ) u_sym_ram (
        .aclk    (aclk),
        .wr_en   (cmd.sym_wr && sym_in_range),
        .wr_addr (symbol[SYM_AW-1:0]),
        .wr_data ({sym_count, sym_base}),
        .rd_en   (cmd.sym_rd),
        .rd_addr (symbol[SYM_AW-1:0]),
        .rd_data (sym_rd_data)
    );

    assign rd_count = sym_rd_data[ENT_W-1 -: COUNT_W];
    assign rd_base  = sym_rd_data[BASE_W-1:0];

    // Next-state table
    tans_enc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (TABLE_SIZE)
    ) u_tbl_ram (
        .aclk    (aclk),
        .wr_en   (cmd.tbl_wr),
        .wr_addr (slot[TABLE_AW-1:0]),
        .wr_data (slot_state),
        .rd_en   (cmd.tbl_rd),
        .rd_addr (tbl_index),
        .rd_data (tbl_rd_data)
    );

    // Entry valid bits: an unwritten symbol reads as count zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_valid_reg <= '0;
            sym_ok_reg    <= 1'b0;
        end else begin
            if (cmd.sym_wr && sym_in_range) begin
                sym_valid_reg[symbol[SYM_AW-1:0]] <= 1'b1;
            end
            if (cmd.sym_rd) begin
                sym_ok_reg <= sym_in_range && sym_valid_reg[symbol[SYM_AW-1:0]];
            end
        end
    end

    assign status.sym_zero = !sym_ok_reg || (rd_count == '0);
    assign status.out_free = !m_valid_reg || m_ready;

    // Renormalization: shift until state < 2*count
    assign two_cnt = {rd_count, 1'b0};

    always_comb begin
        for (int i = 0; i < STATE_W; i++) begin
            below_lim[i] = (({1'b0, coder_state_reg} >> i) < two_cnt);
        end
        shift_next = BCNT_W'($countones(~below_lim));
        xs_next    = coder_state_reg >> shift_next;
        emit_next  = coder_state_reg & ~({BITS_W{1'b1}} << shift_next);
    end

    // Slot index: base + (shifted - count), modulo table size
    assign tbl_index = rd_base[TABLE_AW-1:0]
                     + (xs_reg[TABLE_AW-1:0] - rd_count[TABLE_AW-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.shift_ld) begin
            shift_reg <= shift_next;
            xs_reg    <= xs_next;
            emit_reg  <= emit_next;
        end
    end

    // Word kind flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_reg <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            if (cmd.start) begin
                flush_reg <= cmd.flush;
                err_reg   <= 1'b0;
            end else if (cmd.shift_ld) begin
                err_reg   <= status.sym_zero;
            end
        end
    end

    // Coder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coder_state_reg <= STATE_INIT;
        end else if (cmd.out_ld) begin
            if (flush_reg) begin
                coder_state_reg <= STATE_INIT;
            end else if (!err_reg) begin
                coder_state_reg <= tbl_rd_data;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            if (flush_reg) begin
                bits_reg      <= coder_state_reg;
                bit_count_reg <= bit_len(coder_state_reg);
                err_out_reg   <= 1'b0;
            end else if (err_reg) begin
                bits_reg      <= '0;
                bit_count_reg <= '0;
                err_out_reg   <= 1'b1;
            end else begin
                bits_reg      <= emit_reg;
                bit_count_reg <= shift_reg;
                err_out_reg   <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign bits             = bits_reg;
    assign bit_count        = bit_count_reg;
    assign zero_count_error = err_out_reg;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.out_ld)
        else $error("output word overwritten while stalled");

    // A flush leaves the coder in its initial state
    a_flush_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_ld && flush_reg) |=> (coder_state_reg == STATE_INIT))
        else $error("coder state not reset after flush");

    // A zero-count encode keeps the state and reports no bits
    a_err_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_ld && err_reg && !flush_reg) |=>
            ($stable(coder_state_reg) && bit_count_reg == '0 && err_out_reg))
        else $error("zero-count encode changed state or emitted bits");

    // The table is read only after renormalization found a nonzero count
    a_tbl_after_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tbl_rd |-> ($past(cmd.shift_ld) && !err_reg && !flush_reg))
        else $error("table read without a valid renormalization");

endmodule

`default_nettype wire

### rtl/tans_symbol_encoder.sv
// Top level of the tANS symbol encoder: sequencer plus datapath.
//
//  channel   dir  tdata                         tuser
//  s_        in   slot_state,slot,base,count,sym command (load sym/slot, encode, flush)
//  m_        out  bit_count, bits               zero_count_error
//
// A load word is taken in the idle state, a flush goes straight to the output load,
// an encode does a symbol entry read, renormalization, a next-state table read, then
// the output load (a symbol with count zero skips the table read).
// Reset clears the coder state to 2M-1 and all symbol counts to zero.
// A new word is taken while a result waits on m_; a stalled m_ side holds
// the block in its final step until the output register is free.
`default_nettype none

module tans_symbol_encoder #(
    parameter int ALPHABET = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] symbol, [19:8] sym_count, [30:20] sym_base, [41:31] slot,
    // [53:42] slot_state, [55:54] zero
    input  wire logic [55:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [11:0] bits, [15:12] bit_count
    output logic      [15:0] m_tdata,
    // [0] zero_count_error
    output logic             m_tuser
);

    import tans_enc_pkg::*;

    ctrl_cmd_t           cmd;
    dp_status_t          status;
    cmd_t                command;
    logic [BITS_W-1:0]   bits;
    logic [BCNT_W-1:0]   bit_count;

    assign command = cmd_t'(s_tuser);

    tans_enc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    tans_enc_dpath #(
        .ALPHABET (ALPHABET)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .symbol           (s_tdata[7:0]),
        .sym_count        (s_tdata[19:8]),
        .sym_base         (s_tdata[30:20]),
        .slot             (s_tdata[41:31]),
        .slot_state       (s_tdata[53:42]),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .bits             (bits),
        .bit_count        (bit_count),
        .zero_count_error (m_tuser)
    );

    assign m_tdata = {bit_count, bits};

endmodule

`default_nettype wire

### bench/tb_tans_symbol_encoder.sv
// Self-checking testbench for the tANS symbol encoder: directed and random command words.
`timescale 1ns / 1ps

module tb_tans_symbol_encoder;
    import tans_enc_pkg::*;

    localparam int ALPHA        = 256;
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT_NS = 12 * 400000;

    // Expected code word on m_
    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic [BCNT_W-1:0] nbits;
        logic              zc_err;
    } code_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [7:0] symbol, [19:8] sym_count, [30:20] sym_base, [41:31] slot,
    // [53:42] slot_state, [55:54] zero
    logic [55:0] s_tdata;
    // [1:0] command
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // [11:0] bits, [15:12] bit_count
    logic [15:0] m_tdata;
    // [0] zero_count_error
    logic        m_tuser;

    // Encoder model: coder state, symbol entries and next-state table
    logic [STATE_W-1:0] coder_state;
    logic [COUNT_W-1:0] sym_counts [ALPHA];
    logic [BASE_W-1:0]  sym_bases [ALPHA];
    logic [STATE_W-1:0] next_states [TABLE_SIZE];
    bit                 slot_written [TABLE_SIZE];

    code_word_t         expected_codes [$];
    logic [SYM_W-1:0]   live_symbols [$];
    int                 error_count;
    bit                 no_idle;

    tans_symbol_encoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Next coder state, mostly in [M, 2M), sometimes anywhere
    function automatic logic [STATE_W-1:0] rand_state();
        if ($urandom_range(0, 7) == 0)
            return STATE_W'($urandom_range(0, 4095));
        return STATE_W'($urandom_range(TABLE_SIZE, 2 * TABLE_SIZE - 1));
    endfunction

    // Scaled count: mostly in range, some zero, some tiny, some above M
    function automatic logic [COUNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return COUNT_W'($urandom_range(TABLE_SIZE + 1, 4095));
        if (r < 4)
            return COUNT_W'($urandom_range(1, 4));
        return COUNT_W'($urandom_range(1, TABLE_SIZE));
    endfunction

    function automatic logic [55:0] pack_word(input logic [SYM_W-1:0] sym,
                                              input logic [COUNT_W-1:0] cnt,
                                              input logic [BASE_W-1:0] base,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [STATE_W-1:0] sst);
        return {2'b00, sst, slot, base, cnt, sym};
    endfunction

    // Renormalize the current state for sym; returns the table slot, or -1
    // when the symbol has no count
    function automatic int renorm_slot(input logic [SYM_W-1:0] sym, output int shifts);
        int x;
        int c;
        logic [TABLE_AW-1:0] off;
        c      = sym_counts[sym];
        x      = coder_state;
        shifts = 0;
        if (c == 0)
            return -1;
        while (x >= 2 * c) begin
            x = x >> 1;
            shifts++;
        end
        // state below count wraps modulo M
        off = TABLE_AW'(x - c);
        return int'(TABLE_AW'(sym_bases[sym] + off));
    endfunction

    // Apply one accepted word to the model, queue its code word if any
    function automatic void model_word(input cmd_t cmd, input logic [55:0] d);
        code_word_t cw;
        int         idx;
        int         shifts;
        int         len;
        case (cmd)
            CMD_LOAD_SYM: begin
                sym_counts[d[7:0]] = d[19:8];
                sym_bases[d[7:0]]  = d[30:20];
            end
            CMD_LOAD_SLOT: begin
                next_states[d[41:31]]  = d[53:42];
                slot_written[d[41:31]] = 1'b1;
            end
            CMD_ENCODE: begin
                idx = renorm_slot(d[7:0], shifts);
                if (idx < 0) begin
                    cw = '{bits: '0, nbits: '0, zc_err: 1'b1};
                end else begin
                    cw.bits     = coder_state & BITS_W'((1 << shifts) - 1);
                    cw.nbits    = BCNT_W'(shifts);
                    cw.zc_err   = 1'b0;
                    coder_state = next_states[idx];
                end
                expected_codes = {expected_codes, cw};
            end
            CMD_FLUSH: begin
                len = 0;
                for (int i = 0; i < STATE_W; i++)
                    if (coder_state[i])
                        len = i + 1;
                cw.bits     = coder_state;
                cw.nbits    = BCNT_W'(len);
                cw.zc_err   = 1'b0;
                coder_state = STATE_INIT;
                expected_codes = {expected_codes, cw};
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        error_count++;
        $display("MISMATCH at %0t ns: %s expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // Send one word on s_; valid stays up when the next word follows at once
    task automatic send_word(input cmd_t cmd, input logic [55:0] d);
        int wait_n;
        wait_n = draw_wait();
        if (wait_n > 0) begin
            s_tvalid <= 1'b0;
            repeat (wait_n) @(posedge aclk);
        end
        s_tuser  <= cmd;
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        model_word(cmd, d);
    endtask

    task automatic load_symbol(input logic [SYM_W-1:0] sym, input logic [COUNT_W-1:0] cnt,
                               input logic [BASE_W-1:0] base);
        send_word(CMD_LOAD_SYM, pack_word(sym, cnt, base, SLOT_W'($urandom),
                                          STATE_W'($urandom)));
        live_symbols = {live_symbols, sym};
    endtask

    task automatic load_slot(input logic [SLOT_W-1:0] slot, input logic [STATE_W-1:0] sst);
        send_word(CMD_LOAD_SLOT, pack_word(SYM_W'($urandom), COUNT_W'($urandom),
                                           BASE_W'($urandom), slot, sst));
    endtask

    // Encode sym; an unwritten target slot is loaded first
    task automatic encode_symbol(input logic [SYM_W-1:0] sym);
        int idx;
        int shifts;
        idx = renorm_slot(sym, shifts);
        if (idx >= 0 && !slot_written[idx])
            load_slot(SLOT_W'(idx), rand_state());
        send_word(CMD_ENCODE, pack_word(sym, COUNT_W'($urandom), BASE_W'($urandom),
                                        SLOT_W'($urandom), STATE_W'($urandom)));
    endtask

    task automatic flush_state();
        send_word(CMD_FLUSH, pack_word(SYM_W'($urandom), COUNT_W'($urandom),
                                       BASE_W'($urandom), SLOT_W'($urandom),
                                       STATE_W'($urandom)));
    endtask

    // Hold off the sender until every code word is back, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Zero-count error and full-state flush straight out of reset
    task automatic test_reset_state();
        encode_symbol(8'd0);
        flush_state();
    endtask

    // Field extremes: count 1, M and above M, base and slot at both ends
    task automatic test_field_extremes();
        load_symbol(8'd0, 12'd2048, 11'd0);
        load_symbol(8'd255, 12'd1, 11'd2047);
        load_symbol(8'd128, 12'd4095, 11'd1024);
        load_slot(11'd0, 12'd4095);
        load_slot(11'd2047, 12'd2048);
        encode_symbol(8'd255);
        encode_symbol(8'd0);
        encode_symbol(8'd128);
        flush_state();
    endtask

    // State driven to zero and below count, flush of a zero state, count cleared
    task automatic test_zero_state();
        load_symbol(8'd7, 12'd3, 11'd40);
        load_slot(11'd40, 12'd0);
        load_slot(11'd37, 12'd5);
        encode_symbol(8'd7);
        encode_symbol(8'd7);
        flush_state();
        encode_symbol(8'd7);
        flush_state();
        load_symbol(8'd7, 12'd0, 11'd40);
        encode_symbol(8'd7);
    endtask

    // Mostly encodes of loaded symbols, with reloads, slot writes and flushes mixed in
    task automatic test_random_traffic(input int n_words, input bit steady);
        int r;
        no_idle = steady;
        repeat (8)
            load_symbol(SYM_W'($urandom), rand_count(), BASE_W'($urandom));
        for (int i = 0; i < n_words; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                load_symbol(SYM_W'($urandom), rand_count(), BASE_W'($urandom));
            else if (r < 14)
                load_slot(SLOT_W'($urandom), rand_state());
            else if (r < 19)
                flush_state();
            else if (r < 90)
                encode_symbol(live_symbols[$urandom_range(0, live_symbols.size() - 1)]);
            else
                encode_symbol(SYM_W'($urandom));
        end
        wait_idle();
        no_idle = 1'b0;
    endtask

    // Result side: random stall before each word
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare each accepted code word with the oldest expectation
    always @(posedge aclk) begin
        code_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch("code word with none pending, bits", -1,
                                int'(m_tdata[BITS_W-1:0]));
            end else begin
                exp_w = expected_codes.pop_front();
                if (m_tdata[BITS_W-1:0] !== exp_w.bits)
                    report_mismatch("bits", exp_w.bits, m_tdata[BITS_W-1:0]);
                if (m_tdata[BITS_W+BCNT_W-1:BITS_W] !== exp_w.nbits)
                    report_mismatch("bit_count", exp_w.nbits,
                                    m_tdata[BITS_W+BCNT_W-1:BITS_W]);
                if (m_tuser !== exp_w.zc_err)
                    report_mismatch("zero_count_error", exp_w.zc_err, m_tuser);
            end
        end
    end

    // Test sequence
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_LOAD_SYM;
        error_count = 0;
        no_idle     = 1'b0;
        coder_state = STATE_INIT;
        for (int i = 0; i < ALPHA; i++)
            sym_counts[i] = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
            slot_written[i] = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_field_extremes();
        test_zero_state();
        wait_idle();
        // most encodes pull in a slot load, so the word count runs well above these
        test_random_traffic(80, 1'b0);
        test_random_traffic(60, 1'b1);
        test_random_traffic(100, 1'b0);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
